### rtl/kjsd_pkg.sv
// Shared types and constants for the key jog setpoint decoder.
package kjsd_pkg;

    // Axis count and indexes (vehicle axes first, then arm joints)
    localparam int NUM_AXES      = 7;
    localparam int AXIS_FORWARD  = 0;
    localparam int AXIS_LATERAL  = 1;
    localparam int AXIS_VERTICAL = 2;
    localparam int AXIS_HEADING  = 3;
    localparam int AXIS_ARM      = 4;
    localparam int AXIS_HAND     = 5;
    localparam int AXIS_SUPPORT  = 6;

    // Field widths
    localparam int KEY_W      = 8;
    localparam int OUT_W      = 16;
    localparam int LIMIT_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CLASS_W    = 2;
    localparam int OUT_BITS   = NUM_AXES * OUT_W + CLASS_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Default setpoint storage width and limit register reset
    localparam int SETPOINT_WIDTH_DEF = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 48'h0019_0100_FF00;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_ESC     = 8'd27;
    localparam logic [KEY_W-1:0] KEY_BRACKET = 8'd91;
    localparam logic [KEY_W-1:0] KEY_BLANK   = 8'd32;
    localparam logic [KEY_W-1:0] KEY_UPPER_A = 8'd65;
    localparam logic [KEY_W-1:0] KEY_UPPER_Z = 8'd90;
    localparam logic [KEY_W-1:0] KEY_CASE    = 8'd32;
    localparam logic [KEY_W-1:0] KEY_W_LC    = 8'd119;
    localparam logic [KEY_W-1:0] KEY_S_LC    = 8'd115;
    localparam logic [KEY_W-1:0] KEY_A_LC    = 8'd97;
    localparam logic [KEY_W-1:0] KEY_D_LC    = 8'd100;
    localparam logic [KEY_W-1:0] KEY_O_LC    = 8'd111;
    localparam logic [KEY_W-1:0] KEY_L_LC    = 8'd108;
    localparam logic [KEY_W-1:0] KEY_I_LC    = 8'd105;
    localparam logic [KEY_W-1:0] KEY_K_LC    = 8'd107;
    localparam logic [KEY_W-1:0] KEY_U_LC    = 8'd117;
    localparam logic [KEY_W-1:0] KEY_J_LC    = 8'd106;
    localparam logic [KEY_W-1:0] KEY_ARROW_UP    = 8'd65;
    localparam logic [KEY_W-1:0] KEY_ARROW_DOWN  = 8'd66;
    localparam logic [KEY_W-1:0] KEY_ARROW_RIGHT = 8'd67;
    localparam logic [KEY_W-1:0] KEY_ARROW_LEFT  = 8'd68;

    // Per-axis operation chosen by the key decoder
    typedef enum logic [1:0] {
        JOG_HOLD = 2'd0,
        JOG_INC  = 2'd1,
        JOG_DEC  = 2'd2,
        JOG_ZERO = 2'd3
    } t_jog_op;

    // Result classification
    typedef enum logic [CLASS_W-1:0] {
        KC_DROP    = 2'd0,
        KC_APPLIED = 2'd1,
        KC_ESCAPE  = 2'd2
    } t_key_class;

endpackage

### rtl/key_jog_setpoint_decoder_core.sv
// Key jog setpoint decoder: key byte stream in, seven clamped setpoints out.
//
//  channel  | dir | handshake                       | payload
//  ---------+-----+---------------------------------+------------------------------------
//  s_axis   | in  | i_s_axis_tvalid/o_s_axis_tready | key_byte [7:0]
//  m_axis   | out | o_m_axis_tvalid/i_m_axis_tready | 7 x 16-bit setpoints, key_class
//  cfg      | in  | i_cfg_valid/o_cfg_ready         | i_cfg_index, i_cfg_data (48 bits)
//
// One key byte per cycle while the output is not stalled; a taken byte is held in
// the input register, then decoded, jogged and clamped into the result register,
// which offers it on the output.
// Synchronous active-low reset clears setpoints, escape phase and valids; limit
// registers reset to min -1.0, max 1.0, increment 25/256.
// The input register acts as a skid stage: one byte is still taken while the
// result register waits on a stalled output.
module key_jog_setpoint_decoder_core
    import kjsd_pkg::*;
#(
    parameter int SETPOINT_WIDTH = SETPOINT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // key_byte [7:0]
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [KEY_W-1:0]      i_s_axis_tdata,
    // forward_out [15:0], lateral_out [31:16], vertical_out [47:32],
    // heading_out [63:48], arm_out [79:64], hand_out [95:80],
    // support_out [111:96], key_class [113:112], zero [119:114]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // limit register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [LIMIT_W-1:0]    i_cfg_data
);

    typedef enum logic [1:0] {
        ESC_IDLE    = 2'd0,
        ESC_SEEN    = 2'd1,
        ESC_BRACKET = 2'd2
    } t_esc_phase;

    logic [LIMIT_W-1:0]               r_limits [NUM_AXES];
    logic signed [SETPOINT_WIDTH-1:0] r_setpoint [NUM_AXES];
    logic signed [SETPOINT_WIDTH-1:0] n_setpoint [NUM_AXES];
    logic [OUT_W-1:0]                 axis_out [NUM_AXES];
    t_jog_op                          axis_op [NUM_AXES];
    t_esc_phase                       r_phase, n_phase;
    t_key_class                       r_class, n_class;
    logic [OUT_W-1:0]                 r_out [NUM_AXES];
    logic                             r_in_valid;
    logic [KEY_W-1:0]                 r_in_key;
    logic                             r_out_valid;
    logic                             fire;
    logic [KEY_W-1:0]                 key_lc;

    // stage handshakes
    assign fire            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;

    // limit registers; indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_limits[a] <= LIMIT_RESET;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                if (i_cfg_index == CFG_IDX_W'(a)) begin
                    r_limits[a] <= i_cfg_data;
                end
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_key <= i_s_axis_tdata;
        end
    end

    // fold upper-case letters onto lower case
    assign key_lc = (r_in_key >= KEY_UPPER_A && r_in_key <= KEY_UPPER_Z) ?
                    r_in_key + KEY_CASE : r_in_key;

    // key decode: escape phase, per-axis op, class
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            axis_op[a] = JOG_HOLD;
        end
        n_phase = ESC_IDLE;
        n_class = KC_DROP;
        case (r_phase)
            ESC_SEEN: begin
                if (r_in_key == KEY_BRACKET) begin
                    n_phase = ESC_BRACKET;
                    n_class = KC_ESCAPE;
                end
            end
            ESC_BRACKET: begin
                n_class = KC_APPLIED;
                if (r_in_key == KEY_ARROW_UP) begin
                    axis_op[AXIS_VERTICAL] = JOG_DEC;
                end else if (r_in_key == KEY_ARROW_DOWN) begin
                    axis_op[AXIS_VERTICAL] = JOG_INC;
                end else if (r_in_key == KEY_ARROW_RIGHT) begin
                    axis_op[AXIS_LATERAL] = JOG_INC;
                end else if (r_in_key == KEY_ARROW_LEFT) begin
                    axis_op[AXIS_LATERAL] = JOG_DEC;
                end else begin
                    n_class = KC_DROP;
                end
            end
            default: begin
                n_class = KC_APPLIED;
                if (r_in_key == KEY_ESC) begin
                    n_phase = ESC_SEEN;
                    n_class = KC_ESCAPE;
                end else if (key_lc == KEY_W_LC) begin
                    axis_op[AXIS_FORWARD] = JOG_INC;
                end else if (key_lc == KEY_S_LC) begin
                    axis_op[AXIS_FORWARD] = JOG_DEC;
                end else if (key_lc == KEY_D_LC) begin
                    axis_op[AXIS_HEADING] = JOG_INC;
                end else if (key_lc == KEY_A_LC) begin
                    axis_op[AXIS_HEADING] = JOG_DEC;
                end else if (key_lc == KEY_O_LC) begin
                    axis_op[AXIS_ARM] = JOG_INC;
                end else if (key_lc == KEY_L_LC) begin
                    axis_op[AXIS_ARM] = JOG_DEC;
                end else if (key_lc == KEY_I_LC) begin
                    axis_op[AXIS_HAND] = JOG_INC;
                end else if (key_lc == KEY_K_LC) begin
                    axis_op[AXIS_HAND] = JOG_DEC;
                end else if (key_lc == KEY_U_LC) begin
                    axis_op[AXIS_SUPPORT] = JOG_INC;
                end else if (key_lc == KEY_J_LC) begin
                    axis_op[AXIS_SUPPORT] = JOG_DEC;
                end else if (r_in_key == KEY_BLANK) begin
                    for (int a = 0; a < NUM_AXES; a++) begin
                        axis_op[a] = JOG_ZERO;
                    end
                end else begin
                    n_class = KC_DROP;
                end
            end
        endcase
    end

    // per-axis jog and clamp
    generate
        for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
            kjsd_axis #(
                .SETPOINT_WIDTH (SETPOINT_WIDTH)
            ) u_axis (
                .i_value  (r_setpoint[g]),
                .i_limits (r_limits[g]),
                .i_op     (axis_op[g]),
                .o_next   (n_setpoint[g]),
                .o_out    (axis_out[g])
            );
        end
    endgenerate

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ESC_IDLE;
            r_out_valid <= 1'b0;
            r_class     <= KC_DROP;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_setpoint[a] <= '0;
                r_out[a]      <= '0;
            end
        end else begin
            if (fire) begin
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
                r_class     <= n_class;
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_setpoint[a] <= n_setpoint[a];
                    r_out[a]      <= axis_out[a];
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pack the result
    always_comb begin
        o_m_axis_tdata = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            o_m_axis_tdata[a*OUT_W +: OUT_W] = r_out[a];
        end
        o_m_axis_tdata[NUM_AXES*OUT_W +: CLASS_W] = r_class;
    end

    // a held input byte is not lost while the result stage is blocked
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid)
        else $error("input byte lost while stalled");

    // every processed byte produces a result
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed byte produced no result");

    // a pending escape-class result implies an open escape sequence
    a_esc_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_class == KC_ESCAPE |-> r_phase != ESC_IDLE)
        else $error("escape result without escape phase");

endmodule

### rtl/kjsd_axis.sv
// One setpoint axis: jog by the increment, clamp to the window, saturate to storage width.
module kjsd_axis
    import kjsd_pkg::*;
#(
    parameter int SETPOINT_WIDTH = SETPOINT_WIDTH_DEF
) (
    input  logic signed [SETPOINT_WIDTH-1:0] i_value,
    input  logic        [LIMIT_W-1:0]        i_limits,
    input  t_jog_op                          i_op,
    output logic signed [SETPOINT_WIDTH-1:0] o_next,
    output logic        [OUT_W-1:0]          o_out
);

    localparam int SW    = (SETPOINT_WIDTH > OUT_W) ? SETPOINT_WIDTH : OUT_W;
    localparam int SUM_W = SW + 1;

    // storage range, in the sum width
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - SETPOINT_WIDTH + 1){1'b0}}, {(SETPOINT_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [SUM_W-1:0] cur_ext;
    logic signed [SUM_W-1:0] inc_ext;
    logic signed [SUM_W-1:0] min_ext;
    logic signed [SUM_W-1:0] max_ext;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] win;
    logic signed [SUM_W-1:0] sat;

    assign cur_ext = SUM_W'(i_value);
    assign inc_ext = SUM_W'($signed(i_limits[47:32]));
    assign min_ext = SUM_W'($signed(i_limits[15:0]));
    assign max_ext = SUM_W'($signed(i_limits[31:16]));

    // jog, wide enough never to wrap
    always_comb begin
        case (i_op)
            JOG_INC:  sum = cur_ext + inc_ext;
            JOG_DEC:  sum = cur_ext - inc_ext;
            JOG_ZERO: sum = '0;
            default:  sum = cur_ext;
        endcase
    end

    // window clamp: max test first, then min
    always_comb begin
        if (sum > max_ext) begin
            win = max_ext;
        end else if (sum < min_ext) begin
            win = min_ext;
        end else begin
            win = sum;
        end
    end

    // storage saturation (only bites below 16 bits)
    always_comb begin
        if (win > SAT_HI) begin
            sat = SAT_HI;
        end else if (win < SAT_LO) begin
            sat = SAT_LO;
        end else begin
            sat = win;
        end
    end

    assign o_next = sat[SETPOINT_WIDTH-1:0];

    // result field, always 16 bits
    generate
        if (SETPOINT_WIDTH >= OUT_W) begin : g_wide
            assign o_out = sat[OUT_W-1:0];
        end else begin : g_narrow
            assign o_out = OUT_W'(o_next);
        end
    endgenerate

endmodule

### tb/key_jog_setpoint_decoder_core_test.sv
// Self-checking testbench for the key jog setpoint decoder core.
module key_jog_setpoint_decoder_core_test;
    import kjsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_KEYS   = 150;
    localparam int DRAIN_CYCLES = 4;

    // Escape decoder phases as tracked by the predictor
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ESC     = 2'd1,
        PH_BRACKET = 2'd2
    } t_esc_phase;

    // Shapes of limit register settings
    typedef enum int {
        LIM_RAW,
        LIM_OPEN_FAST_UP,
        LIM_OPEN_FAST_DOWN,
        LIM_INVERTED,
        LIM_WINDOW,
        LIM_RESET
    } t_limit_style;

    // Setpoints and key class after one byte
    typedef struct packed {
        logic [NUM_AXES-1:0][OUT_W-1:0] sp;
        t_key_class                     cls;
    } t_setpoint_frame;

    localparam logic [KEY_W-1:0] JOG_KEYS [10] = '{
        KEY_W_LC, KEY_S_LC, KEY_D_LC, KEY_A_LC, KEY_O_LC,
        KEY_L_LC, KEY_I_LC, KEY_K_LC, KEY_U_LC, KEY_J_LC
    };

    // Tracks setpoints per key byte and checks the result stream against them
    class t_jog_tracker;
        logic [LIMIT_W-1:0] limits [NUM_AXES];
        int                 setpoint [NUM_AXES];
        t_esc_phase         phase;
        t_setpoint_frame    expected_frames [$];
        int                 errors;

        function new();
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                limits[ax]   = LIMIT_RESET;
                setpoint[ax] = 0;
            end
            phase  = PH_IDLE;
            errors = 0;
        endfunction

        function void load_limit(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
            if (idx < NUM_AXES) begin
                limits[idx] = val;
            end
        endfunction

        // Add or subtract the axis increment; int holds the sum without wrap
        function void jog_axis(int ax, bit up);
            int inc;
            inc = $signed(limits[ax][47:32]);
            setpoint[ax] = up ? setpoint[ax] + inc : setpoint[ax] - inc;
        endfunction

        function void apply_key(logic [KEY_W-1:0] k);
            logic [KEY_W-1:0] lc;
            t_key_class       cls;
            t_setpoint_frame  f;
            int               mn;
            int               mx;
            cls = KC_DROP;
            case (phase)
                PH_ESC: begin
                    if (k == KEY_BRACKET) begin
                        phase = PH_BRACKET;
                        cls   = KC_ESCAPE;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
                PH_BRACKET: begin
                    phase = PH_IDLE;
                    cls   = KC_APPLIED;
                    case (k)
                        KEY_ARROW_UP:    jog_axis(AXIS_VERTICAL, 1'b0);
                        KEY_ARROW_DOWN:  jog_axis(AXIS_VERTICAL, 1'b1);
                        KEY_ARROW_RIGHT: jog_axis(AXIS_LATERAL, 1'b1);
                        KEY_ARROW_LEFT:  jog_axis(AXIS_LATERAL, 1'b0);
                        default:         cls = KC_DROP;
                    endcase
                end
                default: begin
                    lc    = (k >= KEY_UPPER_A && k <= KEY_UPPER_Z) ? k + KEY_CASE : k;
                    phase = PH_IDLE;
                    cls   = KC_APPLIED;
                    if (k == KEY_ESC) begin
                        phase = PH_ESC;
                        cls   = KC_ESCAPE;
                    end else if (k == KEY_BLANK) begin
                        for (int ax = 0; ax < NUM_AXES; ax++) setpoint[ax] = 0;
                    end else begin
                        case (lc)
                            KEY_W_LC: jog_axis(AXIS_FORWARD, 1'b1);
                            KEY_S_LC: jog_axis(AXIS_FORWARD, 1'b0);
                            KEY_D_LC: jog_axis(AXIS_HEADING, 1'b1);
                            KEY_A_LC: jog_axis(AXIS_HEADING, 1'b0);
                            KEY_O_LC: jog_axis(AXIS_ARM, 1'b1);
                            KEY_L_LC: jog_axis(AXIS_ARM, 1'b0);
                            KEY_I_LC: jog_axis(AXIS_HAND, 1'b1);
                            KEY_K_LC: jog_axis(AXIS_HAND, 1'b0);
                            KEY_U_LC: jog_axis(AXIS_SUPPORT, 1'b1);
                            KEY_J_LC: jog_axis(AXIS_SUPPORT, 1'b0);
                            default:  cls = KC_DROP;
                        endcase
                    end
                end
            endcase
            // Clamp every axis after every byte: max test first, then min
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                mn = $signed(limits[ax][15:0]);
                mx = $signed(limits[ax][31:16]);
                if (setpoint[ax] > mx) begin
                    setpoint[ax] = mx;
                end else if (setpoint[ax] < mn) begin
                    setpoint[ax] = mn;
                end
                f.sp[ax] = setpoint[ax][OUT_W-1:0];
            end
            f.cls = cls;
            expected_frames.insert(expected_frames.size(), f);
        endfunction

        function void check_frame(logic [OUT_DATA_W-1:0] data);
            t_setpoint_frame  want;
            logic [OUT_W-1:0] got;
            if (expected_frames.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, actual %h", $time, data);
                return;
            end
            want = expected_frames.pop_front();
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                got = data[ax*OUT_W +: OUT_W];
                if (got !== want.sp[ax]) begin
                    errors++;
                    $display("%0t: axis %0d setpoint expected %h actual %h",
                             $time, ax, want.sp[ax], got);
                end
            end
            if (data[NUM_AXES*OUT_W +: CLASS_W] !== want.cls) begin
                errors++;
                $display("%0t: key class expected %0d actual %0d", $time, want.cls,
                         data[NUM_AXES*OUT_W +: CLASS_W]);
            end
        endfunction

        function int frames_pending();
            return expected_frames.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [KEY_W-1:0]      i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [LIMIT_W-1:0]    i_cfg_data = '0;

    t_jog_tracker tracker = new();
    int           cycle_count = 0;
    int           ready_hold = 0;
    int           keys_sent = 0;
    bit           calm = 1'b0;

    key_jog_setpoint_decoder_core dut (.*);

    always #6 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("key_jog_setpoint_decoder_core: mismatch");
            $finish;
        end
    end

    // Output side stalls in random bursts unless calm
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold      <= ready_hold - 1;
            i_m_axis_tready <= (ready_hold == 1);
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            ready_hold      <= $urandom_range(1, 9);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Watch every transfer on the three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) tracker.load_limit(i_cfg_index, i_cfg_data);
            if (i_s_axis_tvalid && o_s_axis_tready) tracker.apply_key(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready) tracker.check_frame(o_m_axis_tdata);
        end
    end

    // Valid stays high after a transfer so back-to-back keys need no second assignment
    task automatic send_key(input logic [KEY_W-1:0] k);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= k;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        keys_sent++;
    endtask

    // Caller lowers the valid once the whole batch is written
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                               input logic [LIMIT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Let the last accepted key reach the tracker before checking that no result is pending
    task automatic wait_drained();
        @(posedge i_clk);
        while (tracker.frames_pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [LIMIT_W-1:0] pick_limits(t_limit_style style);
        logic [63:0]        raw;
        logic signed [15:0] mn;
        logic signed [15:0] mx;
        logic signed [15:0] inc;
        int                 v;
        raw = {$urandom, $urandom};
        inc = raw[15:0];
        case (style)
            LIM_OPEN_FAST_UP:   return {16'h7FFF, 16'h7FFF, 16'h8000};
            LIM_OPEN_FAST_DOWN: return {16'h8000, 16'h7FFF, 16'h8000};
            LIM_INVERTED: begin
                mn = 16'($urandom_range(0, 32767));
                mx = 16'h8000 | 16'($urandom_range(0, 32767));
                return {inc, mx, mn};
            end
            LIM_WINDOW: begin
                v   = $urandom_range(0, 1024);
                mn  = 16'(-v);
                mx  = 16'($urandom_range(0, 1024));
                inc = 16'($urandom_range(1, 512));
                return {inc, mx, mn};
            end
            LIM_RESET: return LIMIT_RESET;
            default:   return raw[LIMIT_W-1:0];
        endcase
    endfunction

    // One keystroke or key sequence, mostly well formed
    task automatic send_keystroke();
        logic [KEY_W-1:0] k;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            k = JOG_KEYS[$urandom_range(0, 9)];
            if ($urandom_range(0, 1) == 1) k = k - KEY_CASE;
            send_key(k);
        end else if (pick < 60) begin
            send_key(KEY_ESC);
            send_key(KEY_BRACKET);
            send_key(KEY_ARROW_UP + KEY_W'($urandom_range(0, 3)));
        end else if (pick < 63) begin
            send_key(KEY_BLANK);
        end else if (pick < 70) begin
            send_key(KEY_ESC);
            send_key(KEY_W'($urandom));
        end else if (pick < 77) begin
            send_key(KEY_ESC);
            send_key(KEY_BRACKET);
            send_key(KEY_W'($urandom));
        end else begin
            send_key(KEY_W'($urandom));
        end
    endtask

    initial begin
        logic [KEY_W-1:0] directed [$];
        t_limit_style     style;
        int               target;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every jog key (alternating lower and upper case), all arrows, broken escapes, space, extremes
        directed = '{KEY_W_LC, KEY_S_LC - KEY_CASE, KEY_D_LC, KEY_A_LC - KEY_CASE,
                     KEY_O_LC, KEY_L_LC - KEY_CASE, KEY_I_LC, KEY_K_LC - KEY_CASE,
                     KEY_U_LC, KEY_J_LC - KEY_CASE,
                     KEY_ESC, KEY_BRACKET, KEY_ARROW_UP, KEY_ESC, KEY_BRACKET, KEY_ARROW_DOWN,
                     KEY_ESC, KEY_BRACKET, KEY_ARROW_RIGHT, KEY_ESC, KEY_BRACKET, KEY_ARROW_LEFT,
                     KEY_ESC, 8'h00, KEY_ESC, KEY_BRACKET, 8'hFF,
                     KEY_BLANK, 8'h00, 8'hFF};
        foreach (directed[i]) send_key(directed[i]);

        // Random phases, each under a fresh set of limits
        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            i_s_axis_tvalid <= 1'b0;
            wait_drained();
            for (int r = 0; r < NUM_AXES; r++) begin
                if (ph <= 2) begin
                    style = t_limit_style'((ph * 3 + r) % 6);
                end else begin
                    style = t_limit_style'($urandom_range(0, 5));
                end
                write_limit(CFG_IDX_W'(r), pick_limits(style));
            end
            // Index past the last axis must be ignored
            write_limit(CFG_IDX_W'(NUM_AXES), pick_limits(LIM_RAW));
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
            calm   = (ph == NUM_PHASES);
            target = keys_sent + PHASE_KEYS;
            while (keys_sent < target) send_keystroke();
        end

        i_s_axis_tvalid <= 1'b0;
        wait_drained();
        if (tracker.errors == 0) begin
            $display("key_jog_setpoint_decoder_core: match");
        end else begin
            $display("key_jog_setpoint_decoder_core: mismatch");
        end
        $finish;
    end

endmodule
